FILE: rtl/core/sidt_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared definitions
// Widths, character codes and the conversion result type of the conversion
// and emit stages, and the BCD digit adjust function of the conversion stage.
// ----------------------------------------------------------------------------
package sidt_pkg;

  localparam int VALUE_W             = 32;
  localparam int CHAR_W              = 6;
  localparam int WIDTH_W             = 6;
  localparam int NUM_DIGITS          = 10;
  localparam int DIGIT_W             = 4;
  localparam int BCD_W               = NUM_DIGITS * DIGIT_W;
  localparam int DIGIT_IDX_W         = 4;
  localparam int STEP_CNT_W          = 5;
  localparam int DEF_MAX_FIELD_WIDTH = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_result_t;

  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        res[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/sidt_dabble.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: binary to BCD converter
// Takes the magnitude of the item's value and converts it to ten BCD digits
// with one shift-and-adjust step per cycle.
// ----------------------------------------------------------------------------
module sidt_dabble
  import sidt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               busy,
  output logic               done,
  output conv_result_t       result
);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic                  neg_r, neg_nxt;
  logic [BCD_W-1:0]      bcd_adj;

  assign bcd_adj = bcd_adjust(bcd_r);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      neg_nxt = value[VALUE_W-1];
      bin_nxt = value[VALUE_W-1] ? (~value + 1'b1) : value;
      bcd_nxt = '0;
    end else if (run_r) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
      cnt_nxt            = cnt_r + 1'b1;
      if (cnt_r == STEP_CNT_W'(VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign busy       = run_r | done_r;
  assign done       = done_r;
  assign result.neg = neg_r;
  assign result.bcd = bcd_r;

endmodule

FILE: rtl/core/sidt_emit.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: character emitter
// Sequences padding spaces, the sign and the digits of one converted item
// into a registered output channel, one character per handshake.
// ----------------------------------------------------------------------------
module sidt_emit
  import sidt_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  conv_result_t       conv,
  input  logic [WIDTH_W-1:0] min_width,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_last
);

  localparam int WW    = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int CMP_W = (WW > WIDTH_W) ? WW : WIDTH_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PAD   = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic                   valid_r, valid_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   last_r, last_nxt;
  logic [WW-1:0]          pad_r, pad_nxt;
  logic [DIGIT_IDX_W-1:0] dig_r, dig_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                   neg_r, neg_nxt;

  logic                   free;
  logic [DIGIT_IDX_W-1:0] top_idx;
  logic [CMP_W-1:0]       width_cap;
  logic [CMP_W-1:0]       total;
  logic [WW-1:0]          pad_calc;
  logic [DIGIT_W-1:0]     cur_digit;

  assign free = !valid_r || out_ready;

  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (conv.bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (CMP_W'(min_width) > CMP_W'(MAX_FIELD_WIDTH)) begin
      width_cap = CMP_W'(MAX_FIELD_WIDTH);
    end else begin
      width_cap = CMP_W'(min_width);
    end
    total = CMP_W'(top_idx) + CMP_W'(1) + CMP_W'(conv.neg);
    if (width_cap > total) begin
      pad_calc = WW'(width_cap - total);
    end else begin
      pad_calc = '0;
    end
  end

  assign cur_digit = bcd_r[dig_r*DIGIT_W +: DIGIT_W];

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r && !out_ready;
    char_nxt  = char_r;
    last_nxt  = last_r;
    pad_nxt   = pad_r;
    dig_nxt   = dig_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          bcd_nxt = conv.bcd;
          neg_nxt = conv.neg;
          pad_nxt = pad_calc;
          dig_nxt = top_idx;
          if (pad_calc != '0) begin
            state_nxt = ST_PAD;
          end else if (conv.neg) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_PAD: begin
        if (free) begin
          valid_nxt = 1'b1;
          char_nxt  = CH_SPACE;
          last_nxt  = 1'b0;
          pad_nxt   = pad_r - 1'b1;
          if (pad_r == WW'(1)) begin
            state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (free) begin
          valid_nxt = 1'b1;
          char_nxt  = CH_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (free) begin
          valid_nxt = 1'b1;
          char_nxt  = CH_ZERO + CHAR_W'(cur_digit);
          last_nxt  = (dig_r == '0);
          dig_nxt   = dig_r - 1'b1;
          if (dig_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    char_r <= char_nxt;
    last_r <= last_nxt;
    pad_r  <= pad_nxt;
    dig_r  <= dig_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

FILE: rtl/core/signed_int_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text unit
// Converts a signed 32-bit value to its decimal ASCII text, one character
// per output item, with optional leading-space padding to a minimum width.
// ----------------------------------------------------------------------------
// Each input item is taken into the shift-and-adjust BCD converter when it
// is accepted, converted one step per cycle, handed to the emitter by the
// converter's done pulse and then sent one character per cycle while
// out_ready is high; the character count is the larger of min_width (capped
// at MAX_FIELD_WIDTH) and the text length including the sign. A new item is
// accepted once the final character of the previous one is in the output
// register. The register min_width answers at byte addresses 0 to 3
// (cfg_paddr[2] low); writes to 4 to 7 are ignored and read back as zero.
module signed_int_to_decimal_text_unit
  import sidt_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic REG_MIN_WIDTH = 1'b0;

  logic [WIDTH_W-1:0] min_width_r, min_width_nxt;
  logic               conv_busy;
  logic               conv_done;
  conv_result_t       conv_res;
  logic               emit_busy;
  logic               accept;
  logic               reg_sel;

  assign reg_sel    = (cfg_paddr[2] == REG_MIN_WIDTH);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {{(32 - WIDTH_W){1'b0}}, min_width_r} : 32'd0;

  always_comb begin
    min_width_nxt = min_width_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      min_width_nxt = cfg_pwdata[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r <= '0;
    end else begin
      min_width_r <= min_width_nxt;
    end
  end

  assign in_ready = !conv_busy && !emit_busy;
  assign accept   = in_valid && in_ready;

  sidt_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .value  (in_value),
    .busy   (conv_busy),
    .done   (conv_done),
    .result (conv_res)
  );

  sidt_emit #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (conv_done),
    .conv          (conv_res),
    .min_width     (min_width_r),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

FILE: tb/sv/signed_int_to_decimal_text_unit_test.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text unit: regression
// Sends signed 32-bit values through the unit and checks every emitted
// character and end flag against a local prediction of the decimal text,
// under several minimum field widths, random gaps on both channels and a
// long output hold-off that stalls the input side.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_unit_test;
  import sidt_pkg::*;

  localparam logic [2:0] ADDR_MIN_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_UNUSED    = 3'd4;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         IDLE_LIMIT     = 3000;
  localparam int         DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  text_char_t         pending_chars[$];
  logic [WIDTH_W-1:0] field_width = '0;
  int                 fail_count = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  int                 hold_token = 0;
  int                 hold_seen = 0;
  bit                 steady = 1'b0;

  signed_int_to_decimal_text_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input longint expected, input longint got);
    $display("mismatch in %s: expected %0d, got %0d", what, expected, got);
    fail_count++;
  endtask

  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    int                 digit_vals[10];
    int                 ndig;
    int                 total;
    int                 field;
    int                 pad;
    int                 count;
    int                 n;
    text_char_t         ch;
    neg = value[VALUE_W-1];
    mag = neg ? (32'd0 - value) : value;
    ndig = 0;
    do begin
      digit_vals[ndig] = int'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    total = ndig + (neg ? 1 : 0);
    field = (int'(field_width) > DEF_MAX_FIELD_WIDTH) ? DEF_MAX_FIELD_WIDTH : int'(field_width);
    pad = (field > total) ? field - total : 0;
    count = pad + total;
    n = 0;
    for (int k = 0; k < pad; k++) begin
      ch.code = CH_SPACE;
      ch.last = (n == count - 1);
      pending_chars.push_back(ch);
      n++;
    end
    if (neg) begin
      ch.code = CH_MINUS;
      ch.last = (n == count - 1);
      pending_chars.push_back(ch);
      n++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = CH_ZERO + CHAR_W'(digit_vals[k]);
      ch.last = (n == count - 1);
      pending_chars.push_back(ch);
      n++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic check_char(input logic [CHAR_W-1:0] code, input logic last);
    text_char_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch("unexpected character (none pending)", -1, code);
    end else begin
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        report_mismatch("char_code", want.code, code);
      end
      if (last !== want.last) begin
        report_mismatch("last", want.last, last);
      end
    end
  endtask

  // The receiver checks each accepted character and decides its own ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_char(out_char_code, out_last);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("signed_int_to_decimal_text_unit regression: fail");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_text(value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rdata;
    cfg_access(1'b1, addr, data, rdata);
    if (addr == ADDR_MIN_WIDTH) begin
      field_width = data[WIDTH_W-1:0];
    end
    cfg_access(1'b0, ADDR_MIN_WIDTH, '0, rdata);
    if (rdata !== {{(32-WIDTH_W){1'b0}}, field_width}) begin
      report_mismatch("min_width read-back", field_width, rdata);
    end
    cfg_access(1'b0, ADDR_UNUSED, '0, rdata);
    if (rdata !== 32'd0) begin
      report_mismatch("unused register read-back", 0, rdata);
    end
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    unique case ($urandom_range(0, 4))
      0: return $urandom();
      1: return VALUE_W'($urandom_range(0, 999));
      2: return 32'd0 - VALUE_W'($urandom_range(1, 999));
      3: return 32'h8000_0000 + VALUE_W'($urandom_range(0, 15));
      default: return 32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic test_directed_values();
    logic [VALUE_W-1:0] values[10];
    values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
               32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000, 32'hC465_3601};
    write_register(ADDR_MIN_WIDTH, 32'd0);
    foreach (values[i]) send_value(values[i]);
    drain_results();
  endtask

  task automatic test_width_extremes();
    int widths[6];
    widths = '{1, 11, 12, 32, 33, 63};
    foreach (widths[i]) begin
      write_register(ADDR_MIN_WIDTH, 32'(widths[i]));
      send_value(32'h8000_0000);
      send_value(32'd7);
      drain_results();
    end
  endtask

  task automatic test_unused_address();
    write_register(ADDR_MIN_WIDTH, 32'd6);
    write_register(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_value(32'd42);
    drain_results();
  endtask

  task automatic test_random_values();
    logic [31:0] width;
    for (int phase = 0; phase < 4; phase++) begin
      width = (phase == 0) ? 32'd0 :
              ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 12));
      write_register(ADDR_MIN_WIDTH, width);
      repeat (20) send_value(random_value());
      drain_results();
    end
  endtask

  task automatic test_output_hold_off();
    write_register(ADDR_MIN_WIDTH, 32'd4);
    steady = 1'b1;
    hold_token++;
    repeat (6) send_value(random_value());
    drain_results();
    steady = 1'b0;
  endtask

  task automatic test_steady_stream();
    write_register(ADDR_MIN_WIDTH, 32'd0);
    steady = 1'b1;
    repeat (8) send_value(random_value());
    drain_results();
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_values();
    test_width_extremes();
    test_unused_address();
    test_random_values();
    test_output_hold_off();
    test_steady_stream();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("signed_int_to_decimal_text_unit regression: pass");
    end else begin
      $display("signed_int_to_decimal_text_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sidt_pkg.sv
rtl/core/sidt_dabble.sv
rtl/core/sidt_emit.sv
rtl/core/signed_int_to_decimal_text_unit.sv
tb/sv/signed_int_to_decimal_text_unit_test.sv
